// ===== rtl/sv39ptb_pkg.sv =====
// Shared types, codes and helper functions of the Sv39 page-table builder.
`default_nettype none
package sv39ptb_pkg;

    localparam int INDEX_BITS = 9;
    localparam int PAGE_SHIFT = 12;
    localparam int PPN_SHIFT  = 10;
    localparam int PPN_W      = 44;
    localparam int VA_W       = 39;
    localparam int PA_W       = 56;
    localparam int LVL_W      = 2;
    localparam int CNT_W      = 16;

    typedef enum logic [1:0] {
        OP_MAP       = 2'd0,
        OP_RUN       = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_RESERVE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MAPPED  = 2'd1,
        ST_BADMODE = 2'd2,
        ST_MISS    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MODE_USER_NOEXEC    = 3'd0,
        MODE_RUNTIME_NOEXEC = 3'd1,
        MODE_RUNTIME_FULL   = 3'd2,
        MODE_USER_FULL      = 3'd3,
        MODE_UNTRUSTED      = 3'd4
    } mode_t;

    localparam logic CFG_ENCLAVE_BASE   = 1'b0;
    localparam logic CFG_UNTRUSTED_BASE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    localparam logic [7:0] F_V = 8'h01;
    localparam logic [7:0] F_R = 8'h02;
    localparam logic [7:0] F_W = 8'h04;
    localparam logic [7:0] F_X = 8'h08;
    localparam logic [7:0] F_U = 8'h10;
    localparam logic [7:0] F_A = 8'h40;
    localparam logic [7:0] F_D = 8'h80;

    // Leaf flags for a permission mode; zero marks an invalid mode.
    function automatic logic [7:0] mode_flags(input logic [2:0] mode);
        logic [7:0] f;
        f = 8'h00;
        case (mode)
            MODE_USER_NOEXEC:    f = F_D | F_A | F_R | F_W | F_U | F_V;
            MODE_RUNTIME_NOEXEC: f = F_D | F_A | F_R | F_W | F_V;
            MODE_RUNTIME_FULL:   f = F_D | F_A | F_R | F_W | F_X | F_V;
            MODE_USER_FULL:      f = F_D | F_A | F_R | F_W | F_X | F_U | F_V;
            MODE_UNTRUSTED:      f = F_D | F_A | F_R | F_W | F_V;
            default:             f = 8'h00;
        endcase
        return f;
    endfunction

    // Table index of a virtual address at a given level.
    function automatic logic [INDEX_BITS-1:0] level_index(input logic [VA_W-1:0] va,
                                                          input logic [LVL_W-1:0] lvl);
        logic [INDEX_BITS-1:0] idx;
        idx = '0;
        case (lvl)
            2'd0:    idx = va[20:12];
            2'd1:    idx = va[29:21];
            2'd2:    idx = va[38:30];
            default: idx = '0;
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sv39ptb_store.sv =====
// Page-table word store: one write port, one registered read port, clear sweep after reset.
`default_nettype none
module sv39ptb_store #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [63:0]       wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [63:0]            rd_data,
    output logic                   busy
);

    logic [63:0]       mem [DEPTH];
    logic [63:0]       rd_data_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // Sweep the whole store to zero, one word a cycle.
    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= 64'd0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule
`default_nettype wire

// ===== rtl/sv39_page_table_builder.sv =====
// Top level of the Sv39 page-table builder: walk sequencer, allocators and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | into      | in_valid / in_stall  | opcode, virt_addr, page_mode, page_count
//   out     | out of    | out_valid / out_stall| ok, status, page_addr, copy_needed,
//           |           |                      | pages_done
//   cfg     | into      | cfg_write            | cfg_index, cfg_data
//
// Each directory level takes a read state and a check state, all through the single store port.
// Map and translate walk the levels down to the leaf, reserve walks none, and a run walks
// the directory levels of each page; the result state then hands the result over.
// After reset the store is swept to zero, all TABLE_PAGES*512 words (32768 by default);
// in_stall stays high meanwhile, configuration writes are taken as ever.
// A finished result waits in the output register; the next transfer in is taken meanwhile.
`default_nettype none
module sv39_page_table_builder #(
    parameter int TABLE_PAGES = 64,
    parameter int LEVELS      = 3
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [1:0]   opcode,
    input  wire logic [38:0]  virt_addr,
    input  wire logic [2:0]   page_mode,
    input  wire logic [15:0]  page_count,

    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              ok,
    output logic [1:0]        status,
    output logic [55:0]       page_addr,
    output logic              copy_needed,
    output logic [15:0]       pages_done,

    input  wire logic         cfg_write,
    input  wire logic         cfg_index,
    input  wire logic [43:0]  cfg_data
);

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int SLOT_W = PAGE_W + sv39ptb_pkg::INDEX_BITS;
    localparam int DEPTH  = TABLE_PAGES * (1 << sv39ptb_pkg::INDEX_BITS);
    localparam int PPN_W  = sv39ptb_pkg::PPN_W;
    localparam int VA_W   = sv39ptb_pkg::VA_W;
    localparam int PA_W   = sv39ptb_pkg::PA_W;
    localparam int LVL_W  = sv39ptb_pkg::LVL_W;
    localparam int CNT_W  = sv39ptb_pkg::CNT_W;

    sv39ptb_pkg::state_t state_reg, state_next;

    logic [1:0]        op_reg, op_next;
    logic [VA_W-1:0]   va_reg, va_next;
    logic [2:0]        mode_reg, mode_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [CNT_W-1:0]  n_reg, n_next;

    logic [PPN_W-1:0]  ebase_reg, ebase_next;
    logic [PPN_W-1:0]  ubase_reg, ubase_next;
    logic [PPN_W-1:0]  enp_reg, enp_next;
    logic [PPN_W-1:0]  unp_reg, unp_next;

    logic              res_ok_reg, res_ok_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [PA_W-1:0]   res_pa_reg, res_pa_next;
    logic              res_copy_reg, res_copy_next;
    logic [CNT_W-1:0]  res_done_reg, res_done_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [PA_W-1:0]   out_pa_reg, out_pa_next;
    logic              out_copy_reg, out_copy_next;
    logic [CNT_W-1:0]  out_done_reg, out_done_next;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [63:0]       mem_wdata;
    logic [SLOT_W-1:0] mem_raddr;
    logic [63:0]       mem_rdata;
    logic              store_busy;

    logic              in_xfer;
    logic [PPN_W-1:0]  ptr;
    logic [PPN_W-1:0]  off;
    logic [CNT_W-1:0]  n_inc;
    logic [7:0]        flags;
    logic [PPN_W-1:0]  pg;

    sv39ptb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (SLOT_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata),
        .busy    (store_busy)
    );

    // Take a new item only when idle and the store sweep is over.
    assign in_stall  = (state_reg != sv39ptb_pkg::S_IDLE) || store_busy;
    assign in_xfer   = in_valid && !in_stall;
    assign mem_raddr = {page_reg, sv39ptb_pkg::level_index(va_reg, lvl_reg)};
    assign mem_waddr = mem_raddr;

    // Pointer that the current directory entry leads to, fresh page when invalid.
    assign ptr   = mem_rdata[0] ? mem_rdata[PPN_W+9:10] : enp_reg;
    assign off   = ptr - ebase_reg;
    assign n_inc = n_reg + CNT_W'(1);
    assign flags = sv39ptb_pkg::mode_flags(mode_reg);
    assign pg    = (mode_reg == sv39ptb_pkg::MODE_UNTRUSTED) ? unp_reg : enp_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        va_next         = va_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        lvl_next        = lvl_reg;
        page_next       = page_reg;
        n_next          = n_reg;
        ebase_next      = ebase_reg;
        ubase_next      = ubase_reg;
        enp_next        = enp_reg;
        unp_next        = unp_reg;
        res_ok_next     = res_ok_reg;
        res_status_next = res_status_reg;
        res_pa_next     = res_pa_reg;
        res_copy_next   = res_copy_reg;
        res_done_next   = res_done_reg;
        out_valid_next  = out_valid_reg;
        out_ok_next     = out_ok_reg;
        out_status_next = out_status_reg;
        out_pa_next     = out_pa_reg;
        out_copy_next   = out_copy_reg;
        out_done_next   = out_done_reg;
        mem_we          = 1'b0;
        mem_wdata       = 64'd0;

        // Drop the shown result once it has been transferred.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sv39ptb_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next         = opcode;
                    va_next         = virt_addr;
                    mode_next       = page_mode;
                    count_next      = page_count;
                    lvl_next        = LVL_W'(LEVELS - 1);
                    page_next       = '0;
                    n_next          = '0;
                    res_ok_next     = 1'b0;
                    res_status_next = sv39ptb_pkg::ST_MISS;
                    res_pa_next     = '0;
                    res_copy_next   = 1'b0;
                    res_done_next   = '0;
                    state_next      = sv39ptb_pkg::S_READ;
                    if (opcode == sv39ptb_pkg::OP_RESERVE)
                    begin
                        res_ok_next     = 1'b1;
                        res_status_next = sv39ptb_pkg::ST_DONE;
                        res_pa_next     = {enp_reg, 12'd0};
                        enp_next        = enp_reg + PPN_W'(page_count);
                        state_next      = sv39ptb_pkg::S_RESULT;
                    end
                    else if (opcode == sv39ptb_pkg::OP_RUN && page_count == '0)
                    begin
                        res_ok_next     = 1'b1;
                        res_status_next = sv39ptb_pkg::ST_DONE;
                        state_next      = sv39ptb_pkg::S_RESULT;
                    end
                end
            end

            sv39ptb_pkg::S_READ:
            begin
                state_next = sv39ptb_pkg::S_CHECK;
            end

            sv39ptb_pkg::S_CHECK:
            begin
                if (lvl_reg != '0)
                begin
                    if (!mem_rdata[0] && op_reg == sv39ptb_pkg::OP_TRANSLATE)
                    begin
                        state_next = sv39ptb_pkg::S_RESULT;
                    end
                    else
                    begin
                        if (!mem_rdata[0])
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {10'd0, enp_reg, 9'd0, 1'b1};
                            enp_next  = enp_reg + PPN_W'(1);
                        end
                        if (off >= PPN_W'(TABLE_PAGES))
                        begin
                            res_done_next = n_reg;
                            state_next    = sv39ptb_pkg::S_RESULT;
                        end
                        else
                        begin
                            page_next  = off[PAGE_W-1:0];
                            lvl_next   = lvl_reg - LVL_W'(1);
                            state_next = sv39ptb_pkg::S_READ;
                            if (lvl_reg == LVL_W'(1) && op_reg == sv39ptb_pkg::OP_RUN)
                            begin
                                // One page of the run walked: advance to the next.
                                n_next    = n_inc;
                                va_next   = va_reg + VA_W'(4096);
                                lvl_next  = LVL_W'(LEVELS - 1);
                                page_next = '0;
                                if (n_inc == count_reg)
                                begin
                                    res_ok_next     = 1'b1;
                                    res_status_next = sv39ptb_pkg::ST_DONE;
                                    res_done_next   = n_inc;
                                    state_next      = sv39ptb_pkg::S_RESULT;
                                end
                            end
                        end
                    end
                end
                else
                begin
                    state_next = sv39ptb_pkg::S_RESULT;
                    if (mem_rdata[0])
                    begin
                        res_ok_next     = 1'b1;
                        res_status_next = (op_reg == sv39ptb_pkg::OP_MAP) ?
                                          sv39ptb_pkg::ST_MAPPED : sv39ptb_pkg::ST_DONE;
                        res_pa_next     = {mem_rdata[PPN_W+9:10], 12'd0};
                    end
                    else if (op_reg == sv39ptb_pkg::OP_MAP)
                    begin
                        if (mode_reg == sv39ptb_pkg::MODE_UNTRUSTED)
                        begin
                            unp_next = unp_reg + PPN_W'(1);
                        end
                        else
                        begin
                            enp_next = enp_reg + PPN_W'(1);
                        end
                        if (flags == 8'h00)
                        begin
                            res_status_next = sv39ptb_pkg::ST_BADMODE;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = {10'd0, pg, 2'd0, flags};
                            res_ok_next     = 1'b1;
                            res_status_next = sv39ptb_pkg::ST_DONE;
                            res_pa_next     = {pg, 12'd0};
                            res_copy_next   = (mode_reg == sv39ptb_pkg::MODE_RUNTIME_FULL) ||
                                              (mode_reg == sv39ptb_pkg::MODE_USER_FULL);
                        end
                    end
                end
            end

            sv39ptb_pkg::S_RESULT:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_ok_next     = res_ok_reg;
                    out_status_next = res_status_reg;
                    out_pa_next     = res_pa_reg;
                    out_copy_next   = res_copy_reg;
                    out_done_next   = res_done_reg;
                    state_next      = sv39ptb_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sv39ptb_pkg::S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            case (cfg_index)
                sv39ptb_pkg::CFG_ENCLAVE_BASE:
                begin
                    ebase_next = cfg_data;
                    enp_next   = cfg_data + PPN_W'(1);
                end
                sv39ptb_pkg::CFG_UNTRUSTED_BASE:
                begin
                    ubase_next = cfg_data;
                    unp_next   = cfg_data;
                end
                default:
                begin
                    ebase_next = ebase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sv39ptb_pkg::S_IDLE;
            op_reg         <= '0;
            va_reg         <= '0;
            mode_reg       <= '0;
            count_reg      <= '0;
            lvl_reg        <= '0;
            page_reg       <= '0;
            n_reg          <= '0;
            ebase_reg      <= '0;
            ubase_reg      <= '0;
            enp_reg        <= PPN_W'(1);
            unp_reg        <= '0;
            res_ok_reg     <= 1'b0;
            res_status_reg <= '0;
            res_pa_reg     <= '0;
            res_copy_reg   <= 1'b0;
            res_done_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_ok_reg     <= 1'b0;
            out_status_reg <= '0;
            out_pa_reg     <= '0;
            out_copy_reg   <= 1'b0;
            out_done_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            va_reg         <= va_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            lvl_reg        <= lvl_next;
            page_reg       <= page_next;
            n_reg          <= n_next;
            ebase_reg      <= ebase_next;
            ubase_reg      <= ubase_next;
            enp_reg        <= enp_next;
            unp_reg        <= unp_next;
            res_ok_reg     <= res_ok_next;
            res_status_reg <= res_status_next;
            res_pa_reg     <= res_pa_next;
            res_copy_reg   <= res_copy_next;
            res_done_reg   <= res_done_next;
            out_valid_reg  <= out_valid_next;
            out_ok_reg     <= out_ok_next;
            out_status_reg <= out_status_next;
            out_pa_reg     <= out_pa_next;
            out_copy_reg   <= out_copy_next;
            out_done_reg   <= out_done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = out_ok_reg;
    assign status      = out_status_reg;
    assign page_addr   = out_pa_reg;
    assign copy_needed = out_copy_reg;
    assign pages_done  = out_done_reg;

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> in_stall)
        else $error("item taken during store sweep");

    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sv39ptb_pkg::S_RESULT))
        else $error("result shown without a finished item");

    a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sv39ptb_pkg::S_READ) |=> (state_reg == sv39ptb_pkg::S_CHECK))
        else $error("store read not followed by check");

    a_write_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == sv39ptb_pkg::S_CHECK) && !store_busy)
        else $error("store write outside check");
`endif

endmodule
`default_nettype wire

// ===== tb/sv39_page_table_builder_checker.sv =====
// Checker for the Sv39 page-table builder: predicts every result and compares it.
`timescale 1ns / 1ps
module sv39_page_table_builder_checker #(
    parameter int TABLE_PAGES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_stall,
    input  logic [1:0]   opcode,
    input  logic [38:0]  virt_addr,
    input  logic [2:0]   page_mode,
    input  logic [15:0]  page_count,
    input  logic         out_valid,
    input  logic         out_stall,
    input  logic         ok,
    input  logic [1:0]   status,
    input  logic [55:0]  page_addr,
    input  logic         copy_needed,
    input  logic [15:0]  pages_done,
    input  logic         cfg_write,
    input  logic         cfg_index,
    input  logic [43:0]  cfg_data,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic                 ok;
        sv39ptb_pkg::status_t status;
        logic [55:0]          page_addr;
        logic                 copy_needed;
        logic [15:0]          pages_done;
    } walk_result_t;

    logic [63:0]  page_words [0:TABLE_PAGES*512-1];
    logic [43:0]  enclave_base;
    logic [43:0]  enclave_next;
    logic [43:0]  untrusted_next;
    walk_result_t expected_q [$];

    function automatic logic [8:0] va_index(input logic [38:0] va, input int lvl);
        logic [38:0] sh;
        sh = va >> (sv39ptb_pkg::PAGE_SHIFT + sv39ptb_pkg::INDEX_BITS * lvl);
        return sh[8:0];
    endfunction

    // Follow the directories to the leaf word, allocating missing ones when asked.
    function automatic bit find_leaf(input logic [38:0] va, input bit create,
                                     output int unsigned slot);
        int unsigned pg;
        int unsigned s;
        logic [63:0] e;
        logic [43:0] off;
        pg = 0;
        slot = 0;
        for (int lvl = 2; lvl > 0; lvl--)
        begin
            s = (pg << sv39ptb_pkg::INDEX_BITS) | va_index(va, lvl);
            e = page_words[s];
            if (!e[0])
            begin
                if (!create)
                    return 1'b0;
                e = (64'(enclave_next) << sv39ptb_pkg::PPN_SHIFT) | 64'(sv39ptb_pkg::F_V);
                page_words[s] = e;
                enclave_next = enclave_next + 44'd1;
            end
            off = e[53:10] - enclave_base;
            if (off >= 44'(TABLE_PAGES))
                return 1'b0;
            pg = int'(off);
        end
        slot = (pg << sv39ptb_pkg::INDEX_BITS) | va_index(va, 0);
        return 1'b1;
    endfunction

    function automatic walk_result_t predict_walk(input logic [1:0] op, input logic [38:0] va,
                                                  input logic [2:0] mode,
                                                  input logic [15:0] cnt);
        walk_result_t r;
        int unsigned slot;
        logic [63:0] leaf;
        logic [43:0] pg;
        logic [7:0]  flags;
        logic [7:0]  base_flags;
        logic [38:0] a;
        int unsigned n;
        r = '{ok: 1'b0, status: sv39ptb_pkg::ST_MISS, page_addr: '0, copy_needed: 1'b0,
              pages_done: '0};
        base_flags = sv39ptb_pkg::F_D | sv39ptb_pkg::F_A | sv39ptb_pkg::F_R |
                     sv39ptb_pkg::F_W | sv39ptb_pkg::F_V;
        case (sv39ptb_pkg::opcode_t'(op))
            sv39ptb_pkg::OP_MAP:
            begin
                if (find_leaf(va, 1'b1, slot))
                begin
                    leaf = page_words[slot];
                    if (leaf[0])
                    begin
                        r.ok = 1'b1;
                        r.status = sv39ptb_pkg::ST_MAPPED;
                        r.page_addr = 56'(leaf[53:10]) << sv39ptb_pkg::PAGE_SHIFT;
                    end
                    else
                    begin
                        flags = 8'h00;
                        if (mode == sv39ptb_pkg::MODE_UNTRUSTED)
                        begin
                            pg = untrusted_next;
                            untrusted_next = untrusted_next + 44'd1;
                        end
                        else
                        begin
                            pg = enclave_next;
                            enclave_next = enclave_next + 44'd1;
                        end
                        case (mode)
                            sv39ptb_pkg::MODE_USER_NOEXEC:
                                flags = base_flags | sv39ptb_pkg::F_U;
                            sv39ptb_pkg::MODE_RUNTIME_NOEXEC:
                                flags = base_flags;
                            sv39ptb_pkg::MODE_RUNTIME_FULL:
                                flags = base_flags | sv39ptb_pkg::F_X;
                            sv39ptb_pkg::MODE_USER_FULL:
                                flags = base_flags | sv39ptb_pkg::F_X | sv39ptb_pkg::F_U;
                            sv39ptb_pkg::MODE_UNTRUSTED:
                                flags = base_flags;
                            default:
                                flags = 8'h00;
                        endcase
                        if (flags == 8'h00)
                            r.status = sv39ptb_pkg::ST_BADMODE;
                        else
                        begin
                            page_words[slot] = (64'(pg) << sv39ptb_pkg::PPN_SHIFT) |
                                               64'(flags);
                            r.ok = 1'b1;
                            r.status = sv39ptb_pkg::ST_DONE;
                            r.page_addr = 56'(pg) << sv39ptb_pkg::PAGE_SHIFT;
                            r.copy_needed = (mode == sv39ptb_pkg::MODE_RUNTIME_FULL) ||
                                            (mode == sv39ptb_pkg::MODE_USER_FULL);
                        end
                    end
                end
            end
            sv39ptb_pkg::OP_RUN:
            begin
                a = va;
                n = 0;
                while (n < cnt)
                begin
                    if (!find_leaf(a, 1'b1, slot))
                        break;
                    a = a + 39'h1000;
                    n++;
                end
                r.pages_done = 16'(n);
                if (n == cnt)
                begin
                    r.ok = 1'b1;
                    r.status = sv39ptb_pkg::ST_DONE;
                end
            end
            sv39ptb_pkg::OP_TRANSLATE:
            begin
                if (find_leaf(va, 1'b0, slot))
                begin
                    leaf = page_words[slot];
                    if (leaf[0])
                    begin
                        r.ok = 1'b1;
                        r.status = sv39ptb_pkg::ST_DONE;
                        r.page_addr = 56'(leaf[53:10]) << sv39ptb_pkg::PAGE_SHIFT;
                    end
                end
            end
            default:
            begin
                r.page_addr = 56'(enclave_next) << sv39ptb_pkg::PAGE_SHIFT;
                enclave_next = enclave_next + 44'(cnt);
                r.ok = 1'b1;
                r.status = sv39ptb_pkg::ST_DONE;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_PAGES * 512; i++)
                page_words[i] = '0;
            enclave_base   = '0;
            enclave_next   = 44'd1;
            untrusted_next = '0;
            expected_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == sv39ptb_pkg::CFG_ENCLAVE_BASE)
                begin
                    enclave_base = cfg_data;
                    enclave_next = cfg_data + 44'd1;
                end
                else
                    untrusted_next = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: ok=%0b status=%0d pa=%h",
                             $time, ok, status, page_addr);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    pending--;
                    if (ok !== want.ok || status !== want.status ||
                        page_addr !== want.page_addr || copy_needed !== want.copy_needed ||
                        pages_done !== want.pages_done)
                    begin
                        $display("%0t: mismatch expected ok=%0b st=%0d pa=%h cp=%0b pd=%0d",
                                 $time, want.ok, want.status, want.page_addr,
                                 want.copy_needed, want.pages_done);
                        $display("%0t:          actual   ok=%0b st=%0d pa=%h cp=%0b pd=%0d",
                                 $time, ok, status, page_addr, copy_needed, pages_done);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(predict_walk(opcode, virt_addr, page_mode, page_count));
                pending++;
            end
        end
    end

endmodule

// ===== tb/tb_sv39_page_table_builder.sv =====
// Testbench top for the Sv39 page-table builder: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_sv39_page_table_builder;

    // Sweep of the whole store after reset plus long walks under heavy stalls.
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 120;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [1:0]   opcode = '0;
    logic [38:0]  virt_addr = '0;
    logic [2:0]   page_mode = '0;
    logic [15:0]  page_count = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic         ok;
    logic [1:0]   status;
    logic [55:0]  page_addr;
    logic         copy_needed;
    logic [15:0]  pages_done;
    logic         cfg_write = 1'b0;
    logic         cfg_index = 1'b0;
    logic [43:0]  cfg_data = '0;

    int errors;
    int pending;
    int cycles = 0;
    int in_idle_pct = 24;
    int out_idle_pct = 67;
    int hold_requests = 0;

    logic [38:0] recent_va [0:15];
    logic [8:0]  top_pool [0:1];
    logic [8:0]  mid_pool [0:2];

    always #5 clk = ~clk;

    sv39_page_table_builder dut (
        .clk, .rst_n, .in_valid, .in_stall, .opcode, .virt_addr, .page_mode, .page_count,
        .out_valid, .out_stall, .ok, .status, .page_addr, .copy_needed, .pages_done,
        .cfg_write, .cfg_index, .cfg_data
    );

    sv39_page_table_builder_checker checker_i (
        .clk, .rst_n, .in_valid, .in_stall, .opcode, .virt_addr, .page_mode, .page_count,
        .out_valid, .out_stall, .ok, .status, .page_addr, .copy_needed, .pages_done,
        .cfg_write, .cfg_index, .cfg_data, .errors, .pending
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
    initial
    begin
        int served;
        int hold_left;
        served = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != served)
            begin
                served = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < out_idle_pct);
        end
    end

    // Offer one transfer and hold it until the block takes it; ends on a falling edge.
    task automatic send_op(input sv39ptb_pkg::opcode_t op, input logic [38:0] va,
                           input logic [2:0] mode, input logic [15:0] cnt);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        opcode     = op;
        virt_addr  = va;
        page_mode  = mode;
        page_count = cnt;
        #1;
        while (in_stall)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
    endtask

    // Drain every result, let the block settle, then write one register.
    task automatic write_reg(input logic idx, input logic [43:0] value);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic logic [43:0] rand_page();
        return 44'({$urandom, $urandom});
    endfunction

    // Addresses mostly fall under a few directories so that walks reuse tables.
    function automatic logic [38:0] pick_va();
        logic [38:0] va;
        if ($urandom_range(99) < 40)
            return recent_va[$urandom_range(15)];
        if ($urandom_range(99) < 10)
            return 39'({$urandom, $urandom});
        va = {top_pool[$urandom_range(1)], mid_pool[$urandom_range(2)],
              9'($urandom_range(31)), 12'($urandom)};
        recent_va[$urandom_range(15)] = va;
        return va;
    endfunction

    initial
    begin
        logic [38:0] va;
        logic [2:0]  mode;
        logic [15:0] cnt;
        int          pick;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int i = 0; i < 16; i++)
            recent_va[i] = '0;

        write_reg(sv39ptb_pkg::CFG_ENCLAVE_BASE, 44'd0);
        write_reg(sv39ptb_pkg::CFG_UNTRUSTED_BASE, 44'h800);

        // Every mode, including the invalid ones, then remaps and translations.
        for (int m = 0; m < 8; m++)
            send_op(sv39ptb_pkg::OP_MAP, 39'(m) << 12, 3'(m), 16'd0);
        send_op(sv39ptb_pkg::OP_MAP, 39'h0, sv39ptb_pkg::MODE_USER_FULL, 16'd0);
        send_op(sv39ptb_pkg::OP_TRANSLATE, 39'h2abc, 3'd0, 16'd0);
        send_op(sv39ptb_pkg::OP_TRANSLATE, 39'h5000, 3'd0, 16'd0);
        send_op(sv39ptb_pkg::OP_TRANSLATE, '1, 3'd7, '1);
        send_op(sv39ptb_pkg::OP_MAP, '1, sv39ptb_pkg::MODE_UNTRUSTED, '1);
        send_op(sv39ptb_pkg::OP_TRANSLATE, '1, 3'd0, 16'd0);
        send_op(sv39ptb_pkg::OP_RUN, 39'h40_0000, 3'd0, 16'd0);
        // Run across the top of the address space wraps to zero.
        send_op(sv39ptb_pkg::OP_RUN, 39'h7F_FFFF_E000, 3'd0, 16'd4);
        send_op(sv39ptb_pkg::OP_RESERVE, 39'h0, 3'd0, 16'd0);
        send_op(sv39ptb_pkg::OP_RESERVE, 39'h0, 3'd0, 16'd2);
        send_op(sv39ptb_pkg::OP_RUN, 39'h0, 3'd0, 16'd600);
        // Exhaust the enclave allocator: further walks leave the store.
        send_op(sv39ptb_pkg::OP_RESERVE, 39'h0, 3'd0, 16'hFFFF);
        send_op(sv39ptb_pkg::OP_RUN, 39'h0, 3'd0, 16'hFFFF);
        send_op(sv39ptb_pkg::OP_MAP, 39'h40_0000_0000, sv39ptb_pkg::MODE_RUNTIME_NOEXEC,
                16'd0);
        send_op(sv39ptb_pkg::OP_TRANSLATE, 39'h40_0000_0000, 3'd0, 16'd0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:
                begin
                    write_reg(sv39ptb_pkg::CFG_ENCLAVE_BASE, 44'h123);
                    write_reg(sv39ptb_pkg::CFG_UNTRUSTED_BASE, '1);
                end
                1:
                begin
                    write_reg(sv39ptb_pkg::CFG_ENCLAVE_BASE, '1);
                    write_reg(sv39ptb_pkg::CFG_UNTRUSTED_BASE, '0);
                end
                2:
                begin
                    write_reg(sv39ptb_pkg::CFG_ENCLAVE_BASE, 44'hFFF_FFFF_FFF0);
                    write_reg(sv39ptb_pkg::CFG_UNTRUSTED_BASE, 44'hFFF_FFFF_FFFE);
                end
                default:
                begin
                    write_reg(sv39ptb_pkg::CFG_ENCLAVE_BASE, rand_page());
                    write_reg(sv39ptb_pkg::CFG_UNTRUSTED_BASE, rand_page());
                end
            endcase
            // Swap the idle ratios by thirds; the last third runs flat out.
            if (seg < 4)
            begin
                in_idle_pct = 24;
                out_idle_pct = 67;
            end
            else if (seg < 8)
            begin
                in_idle_pct = 67;
                out_idle_pct = 24;
            end
            else
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            top_pool[0] = 9'($urandom);
            top_pool[1] = 9'($urandom);
            for (int k = 0; k < 3; k++)
                mid_pool[k] = 9'($urandom);

            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                if ((seg == 2 || seg == 9) && n == 60)
                    hold_requests++;
                va = pick_va();
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    pick = $urandom_range(99);
                    mode = (pick < 40) ? sv39ptb_pkg::MODE_UNTRUSTED :
                           (pick < 93) ? 3'($urandom_range(3)) : 3'($urandom_range(7, 5));
                    send_op(sv39ptb_pkg::OP_MAP, va, mode, 16'($urandom));
                end
                else if (pick < 65)
                    send_op(sv39ptb_pkg::OP_TRANSLATE, va, 3'($urandom), 16'($urandom));
                else if (pick < 80)
                begin
                    cnt = ($urandom_range(39) == 0) ? 16'($urandom_range(600))
                                                   : 16'($urandom_range(8));
                    send_op(sv39ptb_pkg::OP_RUN, va, 3'($urandom), cnt);
                end
                else
                begin
                    cnt = ($urandom_range(49) == 0) ? 16'($urandom) : 16'($urandom_range(3));
                    send_op(sv39ptb_pkg::OP_RESERVE, va, 3'($urandom), cnt);
                end
            end
        end

        // Drop valid, drain, and give the block time to show any stray result.
        in_valid = 1'b0;
        in_idle_pct = 0;
        out_idle_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sv39ptb_pkg.sv
rtl/sv39ptb_store.sv
rtl/sv39_page_table_builder.sv
tb/sv39_page_table_builder_checker.sv
tb/tb_sv39_page_table_builder.sv
